@@ hw/rtl/tpt_pkg.sv @@
// ----------------------------------------------------------------------------
// tpt_pkg
// Shared sizes, codes and result type of the timed ping table.
// ----------------------------------------------------------------------------
package tpt_pkg;

  localparam int PING_SLOTS    = 8;
  localparam int HISTORY_DEPTH = 8;
  localparam int MAX_RESULTS   = 8;

  localparam int SlotIdxW = (PING_SLOTS > 1) ? $clog2(PING_SLOTS) : 1;
  localparam int HistIdxW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HistCntW = $clog2(HISTORY_DEPTH + 1);
  localparam int ListCntW = $clog2(MAX_RESULTS + 1);

  localparam int PosW       = 64;
  localparam int SlotEntryW = 128;
  localparam int InDataW    = 144;
  localparam int OutDataW   = 72;

  localparam logic [7:0] SPACE_KEY = 8'd32;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_KEY   = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_LIST = 2'd1,
    KIND_KEY  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  slot;
    logic [31:0] x;
    logic [31:0] y;
    logic        repl;
    logic        handled;
    logic        cam;
    logic        quick;
    logic        last;
  } res_t;

  function automatic logic [2:0] slot_field(input logic [SlotIdxW-1:0] idx);
    logic [SlotIdxW+2:0] w;
    w = {3'b000, idx};
    return w[2:0];
  endfunction

endpackage

@@ hw/rtl/tpt_ram.sv @@
// ----------------------------------------------------------------------------
// tpt_ram
// Single write port, single read port ram with registered read data.
// ----------------------------------------------------------------------------
module tpt_ram #(
  parameter int Width = 64,
  parameter int Depth = 8
) (
  input  logic                                           clk_i,
  input  logic                                           we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]   waddr_i,
  input  logic [Width-1:0]                               wdata_i,
  input  logic                                           re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]   raddr_i,
  output logic [Width-1:0]                               rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/tpt_outbuf.sv @@
// ----------------------------------------------------------------------------
// tpt_outbuf
// Output register for result beats, packs the result onto the master side.
// ----------------------------------------------------------------------------
module tpt_outbuf (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  tpt_pkg::res_t                 res_i,
  output logic                          free_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // slot, out_x, out_y, replaced_oldest, handled, camera_set, quick_camera
  output logic [tpt_pkg::OutDataW-1:0]  m_axis_tdata,
  // kind
  output logic [1:0]                    m_axis_tuser,
  output logic                          m_axis_tlast
);

  logic          valid_q, valid_d;
  tpt_pkg::res_t res_q;

  assign free_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {1'b0, res_q.quick, res_q.cam, res_q.handled, res_q.repl,
                          res_q.y, res_q.x, res_q.slot};
  assign m_axis_tuser  = res_q.kind;
  assign m_axis_tlast  = res_q.last;

endmodule

@@ hw/rtl/timed_ping_table_with_recall.sv @@
// ----------------------------------------------------------------------------
// timed_ping_table_with_recall
// Timed ping table with recent-position history and round-robin recall.
// ----------------------------------------------------------------------------
// add: write a free slot, or scan for the oldest when all live, then the ack beat
// tick: each slot read and checked through the slot memory, plus stalls; a closing
//   beat follows when anything is listed
// key: one beat, history read first if recalling; clear: no beat; one item at a time
// reset clears live bits, history count, cursor and head at once; the slot and
//   history memories are not cleared and are used only while live or below count
module timed_ping_table_with_recall (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // now_ms, life_ms, ping_x, ping_y, remember, key_code, key_repeat
  input  logic [tpt_pkg::InDataW-1:0]   s_axis_tdata,
  // mode
  input  logic [1:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // slot, out_x, out_y, replaced_oldest, handled, camera_set, quick_camera
  output logic [tpt_pkg::OutDataW-1:0]  m_axis_tdata,
  // kind
  output logic [1:0]                    m_axis_tuser,
  output logic                          m_axis_tlast
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DECODE   = 8'b0000_0010,
    S_SCAN_RD  = 8'b0000_0100,
    S_SCAN_EV  = 8'b0000_1000,
    S_TICK_END = 8'b0001_0000,
    S_ADD_WR   = 8'b0010_0000,
    S_KEY_RD   = 8'b0100_0000,
    S_EMIT     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // input beat
  tpt_pkg::mode_e          mode_q;
  logic [31:0]             now_q, life_q;
  logic [tpt_pkg::PosW-1:0] pos_q;
  logic                    rem_q, rep_q;
  logic [7:0]              key_q;

  logic [tpt_pkg::PING_SLOTS-1:0] live_q, live_d;
  logic [tpt_pkg::SlotIdxW-1:0]   idx_q, idx_d, oldest_q, oldest_d, sel_q, sel_d;
  logic [31:0]                    max_age_q, max_age_d;
  logic                           repl_q, repl_d;
  logic [tpt_pkg::ListCntW-1:0]   n_q, n_d;
  logic                           hold_v_q, hold_v_d;
  tpt_pkg::res_t                  res_q, res_d;

  logic [tpt_pkg::HistCntW-1:0]   cnt_q, cnt_d;
  logic [tpt_pkg::HistIdxW-1:0]   cursor_q, cursor_d, head_q, head_d;

  // memories
  logic                            slot_re, slot_we;
  logic [tpt_pkg::SlotEntryW-1:0]  slot_rdata;
  logic                            hist_re, hist_we;
  logic [tpt_pkg::HistIdxW-1:0]    hist_raddr;
  logic [tpt_pkg::PosW-1:0]        hist_rdata;

  // output
  logic          ob_load, ob_free;
  tpt_pkg::res_t ob_res;

  logic                          in_acc;
  logic                          any_free;
  logic [tpt_pkg::SlotIdxW-1:0]  free_idx;
  logic [31:0]                   age;
  logic                          idx_last, adv;
  logic [tpt_pkg::HistIdxW-1:0]  cur, head_next;
  logic [tpt_pkg::HistCntW-1:0]  cur_next;
  logic [tpt_pkg::HistIdxW:0]    addr_w;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= tpt_pkg::mode_e'(s_axis_tuser);
      now_q  <= s_axis_tdata[31:0];
      life_q <= s_axis_tdata[63:32];
      pos_q  <= s_axis_tdata[127:64];
      rem_q  <= s_axis_tdata[128];
      key_q  <= s_axis_tdata[136:129];
      rep_q  <= s_axis_tdata[137];
    end
  end

  // first free slot
  always_comb begin
    any_free = ~&live_q;
    free_idx = '0;
    for (int i = tpt_pkg::PING_SLOTS - 1; i >= 0; i--) begin
      if (!live_q[i]) begin
        free_idx = tpt_pkg::SlotIdxW'(i);
      end
    end
  end

  // history addressing: entry k lives at head - k
  always_comb begin
    cur = (tpt_pkg::HistCntW'(cursor_q) >= cnt_q) ? '0 : cursor_q;
    cur_next = tpt_pkg::HistCntW'(cur) + tpt_pkg::HistCntW'(1);
    if (head_q >= cur) begin
      addr_w = {1'b0, head_q} - {1'b0, cur};
    end else begin
      addr_w = {1'b0, head_q} + (tpt_pkg::HistIdxW + 1)'(tpt_pkg::HISTORY_DEPTH)
               - {1'b0, cur};
    end
    hist_raddr = addr_w[tpt_pkg::HistIdxW-1:0];
    head_next = (head_q == tpt_pkg::HistIdxW'(tpt_pkg::HISTORY_DEPTH - 1)) ?
                '0 : head_q + tpt_pkg::HistIdxW'(1);
  end

  assign age      = now_q - slot_rdata[31:0];
  assign idx_last = (idx_q == tpt_pkg::SlotIdxW'(tpt_pkg::PING_SLOTS - 1));

  always_comb begin
    state_d      = state_q;
    live_d       = live_q;
    idx_d        = idx_q;
    oldest_d     = oldest_q;
    max_age_d    = max_age_q;
    sel_d        = sel_q;
    repl_d       = repl_q;
    n_d          = n_q;
    hold_v_d     = hold_v_q;
    res_d        = res_q;
    cnt_d        = cnt_q;
    cursor_d     = cursor_q;
    head_d       = head_q;
    slot_re      = 1'b0;
    slot_we      = 1'b0;
    hist_re      = 1'b0;
    hist_we      = 1'b0;
    ob_load      = 1'b0;
    ob_res       = res_q;
    adv          = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (mode_q)
          tpt_pkg::MODE_ADD: begin
            if (life_q == 32'd0) begin
              state_d = S_IDLE;
            end else if (any_free) begin
              sel_d   = free_idx;
              repl_d  = 1'b0;
              state_d = S_ADD_WR;
            end else begin
              idx_d     = '0;
              oldest_d  = '0;
              max_age_d = '0;
              state_d   = S_SCAN_RD;
            end
          end
          tpt_pkg::MODE_TICK: begin
            idx_d    = '0;
            n_d      = '0;
            hold_v_d = 1'b0;
            state_d  = S_SCAN_RD;
          end
          tpt_pkg::MODE_KEY: begin
            res_d      = '0;
            res_d.kind = tpt_pkg::KIND_KEY;
            state_d    = S_EMIT;
            if (key_q == tpt_pkg::SPACE_KEY) begin
              res_d.handled = 1'b1;
              if (!rep_q) begin
                if (cnt_q != '0) begin
                  hist_re   = 1'b1;
                  res_d.cam = 1'b1;
                  cursor_d  = (cur_next >= cnt_q) ? '0 :
                              cur_next[tpt_pkg::HistIdxW-1:0];
                  state_d   = S_KEY_RD;
                end else begin
                  res_d.quick = 1'b1;
                end
              end
            end
          end
          tpt_pkg::MODE_CLEAR: begin
            live_d   = '0;
            cnt_d    = '0;
            cursor_d = '0;
            state_d  = S_IDLE;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_SCAN_RD: begin
        slot_re = 1'b1;
        state_d = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (mode_q == tpt_pkg::MODE_ADD) begin
          if (age >= max_age_q) begin
            oldest_d  = idx_q;
            max_age_d = age;
          end
          if (idx_last) begin
            sel_d   = (age >= max_age_q) ? idx_q : oldest_q;
            repl_d  = 1'b1;
            state_d = S_ADD_WR;
          end else begin
            idx_d   = idx_q + tpt_pkg::SlotIdxW'(1);
            state_d = S_SCAN_RD;
          end
        end else begin
          if (live_q[idx_q]) begin
            if (age >= slot_rdata[63:32]) begin
              live_d[idx_q] = 1'b0;
            end else if (n_q < tpt_pkg::ListCntW'(tpt_pkg::MAX_RESULTS)) begin
              if (hold_v_q && !ob_free) begin
                adv = 1'b0;
              end else begin
                ob_load     = hold_v_q;
                ob_res.last = 1'b0;
                res_d       = '0;
                res_d.kind  = tpt_pkg::KIND_LIST;
                res_d.slot  = tpt_pkg::slot_field(idx_q);
                res_d.x     = slot_rdata[95:64];
                res_d.y     = slot_rdata[127:96];
                hold_v_d    = 1'b1;
                n_d         = n_q + tpt_pkg::ListCntW'(1);
              end
            end
          end
          if (adv) begin
            if (idx_last) begin
              state_d = S_TICK_END;
            end else begin
              idx_d   = idx_q + tpt_pkg::SlotIdxW'(1);
              state_d = S_SCAN_RD;
            end
          end
        end
      end
      S_TICK_END: begin
        state_d = hold_v_q ? S_EMIT : S_IDLE;
      end
      S_ADD_WR: begin
        slot_we       = 1'b1;
        live_d[sel_q] = 1'b1;
        if (rem_q) begin
          hist_we  = 1'b1;
          head_d   = head_next;
          cursor_d = '0;
          if (cnt_q < tpt_pkg::HistCntW'(tpt_pkg::HISTORY_DEPTH)) begin
            cnt_d = cnt_q + tpt_pkg::HistCntW'(1);
          end
        end
        res_d      = '0;
        res_d.kind = tpt_pkg::KIND_ACK;
        res_d.slot = tpt_pkg::slot_field(sel_q);
        res_d.x    = pos_q[31:0];
        res_d.y    = pos_q[63:32];
        res_d.repl = repl_q;
        state_d    = S_EMIT;
      end
      S_KEY_RD: begin
        res_d.x = hist_rdata[31:0];
        res_d.y = hist_rdata[63:32];
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (ob_free) begin
          ob_load     = 1'b1;
          ob_res.last = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      live_q       <= '0;
      idx_q        <= '0;
      oldest_q     <= '0;
      max_age_q    <= '0;
      sel_q        <= '0;
      repl_q       <= 1'b0;
      n_q          <= '0;
      hold_v_q     <= 1'b0;
      cnt_q        <= '0;
      cursor_q     <= '0;
      head_q       <= '0;
    end else begin
      state_q      <= state_d;
      live_q       <= live_d;
      idx_q        <= idx_d;
      oldest_q     <= oldest_d;
      max_age_q    <= max_age_d;
      sel_q        <= sel_d;
      repl_q       <= repl_d;
      n_q          <= n_d;
      hold_v_q     <= hold_v_d;
      cnt_q        <= cnt_d;
      cursor_q     <= cursor_d;
      head_q       <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  tpt_ram #(
    .Width (tpt_pkg::SlotEntryW),
    .Depth (tpt_pkg::PING_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (sel_q),
    .wdata_i ({pos_q, life_q, now_q}),
    .re_i    (slot_re),
    .raddr_i (idx_q),
    .rdata_o (slot_rdata)
  );

  tpt_ram #(
    .Width (tpt_pkg::PosW),
    .Depth (tpt_pkg::HISTORY_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (head_next),
    .wdata_i (pos_q),
    .re_i    (hist_re),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  tpt_outbuf u_outbuf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (ob_load),
    .res_i         (ob_res),
    .free_o        (ob_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
